// File: rtl/core/crf_pkg.sv
// ----------------------------------------------------------------------------
// crf_pkg
// Shared sizes, codes and controller/datapath signal groups of the closable
// ring FIFO.
// ----------------------------------------------------------------------------
package crf_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned PTR_W    = ADDR_W + 1;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CAPL_W   = 3;
  localparam int unsigned MAXC_W   = 5;

  localparam logic [CAPL_W-1:0] CAPL_RESET = CAPL_W'(4);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_BATCH = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_RESET = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_CLOSED = 3'd3,
    ST_BUSY   = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    close;
    logic    clear;
    logic    ld_imm;
    status_e imm_status;
    logic    ld_word;
    logic    word_last;
  } crf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             full;
    logic             closed;
  } crf_stat_t;

endpackage

// File: rtl/core/crf_datapath.sv
// ----------------------------------------------------------------------------
// crf_datapath
// Ring store, head/tail pointers, close mark, capacity register and the
// result register.
// ----------------------------------------------------------------------------
module crf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crf_pkg::crf_cmd_t             cmd_i,
  output crf_pkg::crf_stat_t            stat_o,
  input  logic [crf_pkg::DATA_W-1:0]    data_i,
  input  logic                          cfg_we_i,
  input  logic [crf_pkg::CAPL_W-1:0]    cfg_data_i,
  output logic [crf_pkg::STATUS_W-1:0]  status_o,
  output logic [crf_pkg::DATA_W-1:0]    data_res_o,
  output logic                          has_data_o,
  output logic                          last_o,
  output logic [crf_pkg::CNT_W-1:0]     count_o,
  output logic                          closed_o,
  output logic                          drained_o
);
  import crf_pkg::*;

  logic [DATA_W-1:0]   mem_q [DEPTH];
  logic [DATA_W-1:0]   rdata_q;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic                closed_q, closed_d;
  logic [CAPL_W-1:0]   capl_q, capl_d;
  logic [CAPL_W-1:0]   capl_sat;
  logic [CNT_W-1:0]    cap;
  logic [ADDR_W-1:0]   addr_mask, head_addr, tail_addr;
  logic [CNT_W-1:0]    fill_q, fill_d;

  logic [STATUS_W-1:0] status_q;
  logic [DATA_W-1:0]   data_res_q;
  logic                has_data_q, last_q, closed_out_q, drained_q;
  logic [CNT_W-1:0]    count_q;

  // Capacity in use saturates at the built depth.
  assign capl_sat  = (capl_q > CAPL_W'(ADDR_W)) ? CAPL_W'(ADDR_W) : capl_q;
  assign cap       = CNT_W'(1) << capl_sat;
  assign addr_mask = ADDR_W'(cap - CNT_W'(1));
  assign head_addr = head_q[ADDR_W-1:0] & addr_mask;
  assign tail_addr = tail_q[ADDR_W-1:0] & addr_mask;
  assign fill_q    = CNT_W'(tail_q - head_q);

  assign stat_o.fill   = fill_q;
  assign stat_o.full   = (fill_q >= cap);
  assign stat_o.closed = closed_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    closed_d = closed_q;
    capl_d   = capl_q;
    if (cfg_we_i) begin
      capl_d   = cfg_data_i;
      head_d   = '0;
      tail_d   = '0;
      closed_d = 1'b0;
    end else begin
      if (cmd_i.clear) begin
        head_d   = '0;
        tail_d   = '0;
        closed_d = 1'b0;
      end
      if (cmd_i.push) tail_d = tail_q + PTR_W'(1);
      if (cmd_i.pop)  head_d = head_q + PTR_W'(1);
      if (cmd_i.close) closed_d = 1'b1;
    end
  end

  assign fill_d = CNT_W'(tail_d - head_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      closed_q <= 1'b0;
      capl_q   <= CAPL_RESET;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      closed_q <= closed_d;
      capl_q   <= capl_d;
    end
  end

  // Ring store: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[tail_addr] <= data_i;
    if (cmd_i.pop)  rdata_q <= mem_q[head_addr];
  end

  // Result register; count and flags reflect the state after this result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_imm) begin
      status_q     <= cmd_i.imm_status;
      data_res_q   <= '0;
      has_data_q   <= 1'b0;
      last_q       <= 1'b1;
      count_q      <= fill_d;
      closed_out_q <= closed_d;
      drained_q    <= closed_d && (fill_d == '0);
    end else if (cmd_i.ld_word) begin
      status_q     <= ST_OK;
      data_res_q   <= rdata_q;
      has_data_q   <= 1'b1;
      last_q       <= cmd_i.word_last;
      count_q      <= fill_d;
      closed_out_q <= closed_d;
      drained_q    <= closed_d && (fill_d == '0);
    end
  end

  assign status_o   = status_q;
  assign data_res_o = data_res_q;
  assign has_data_o = has_data_q;
  assign last_o     = last_q;
  assign count_o    = count_q;
  assign closed_o   = closed_out_q;
  assign drained_o  = drained_q;

endmodule

// File: rtl/core/crf_ctrl.sv
// ----------------------------------------------------------------------------
// crf_ctrl
// Item sequencer: decodes the kind, issues datapath commands and walks batch
// pops one word at a time.
// ----------------------------------------------------------------------------
module crf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [crf_pkg::KIND_W-1:0]  kind_i,
  input  logic [crf_pkg::MAXC_W-1:0]  max_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  crf_pkg::crf_stat_t          stat_i,
  output crf_pkg::crf_cmd_t           cmd_o
);
  import crf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic [CNT_W-1:0] batch_n;
  status_e          empty_status;

  assign empty_status = stat_i.closed ? ST_CLOSED : ST_EMPTY;
  assign batch_n = (CNT_W'(max_count_i) < stat_i.fill) ? CNT_W'(max_count_i) : stat_i.fill;

  always_comb begin
    cmd_o    = '0;
    cmd_o.imm_status = ST_OK;
    state_d  = state_q;
    remain_d = remain_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_OUT;
          unique case (kind_i)
            KIND_PUSH: begin
              cmd_o.ld_imm = 1'b1;
              if (stat_i.closed) begin
                cmd_o.imm_status = ST_CLOSED;
              end else if (stat_i.full) begin
                cmd_o.imm_status = ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            KIND_POP: begin
              if (stat_i.fill == '0) begin
                cmd_o.ld_imm     = 1'b1;
                cmd_o.imm_status = empty_status;
              end else begin
                cmd_o.pop = 1'b1;
                remain_d  = '0;
                state_d   = S_READ;
              end
            end
            KIND_BATCH: begin
              if (max_count_i == '0) begin
                cmd_o.ld_imm = 1'b1;
              end else if (stat_i.fill == '0) begin
                cmd_o.ld_imm     = 1'b1;
                cmd_o.imm_status = empty_status;
              end else begin
                cmd_o.pop = 1'b1;
                remain_d  = batch_n - CNT_W'(1);
                state_d   = S_READ;
              end
            end
            KIND_CLOSE: begin
              cmd_o.close  = 1'b1;
              cmd_o.ld_imm = 1'b1;
            end
            KIND_RESET: begin
              cmd_o.ld_imm = 1'b1;
              if (stat_i.fill != '0) begin
                cmd_o.imm_status = ST_BUSY;
              end else begin
                cmd_o.clear = 1'b1;
              end
            end
            default: begin
              // drop unknown kinds without a result
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.ld_word   = 1'b1;
        cmd_o.word_last = (remain_q == '0);
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (remain_q != '0) begin
            cmd_o.pop = 1'b1;
            remain_d  = remain_q - CNT_W'(1);
            state_d   = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// File: rtl/core/closable_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// closable_ring_fifo_unit
// Ring FIFO of words with a close mark, driven by command items (push, pop,
// batch pop, close, reset) and answering with one or more result items.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  -------------------------------
// in        input      in_valid_i/in_ready_o  kind_i, data_i, max_count_i
// out       output     out_valid_o/out_ready_i status_o, data_res_o, has_data_o,
//                                             last_o, count_o, closed_o, drained_o
// cfg       input      cfg_we_i (no wait)     cfg_data_i (capacity_log2)
//
// Push, close, reset and refused or empty pops load the registered result
// straight from idle; each popped word passes a registered read of the ring
// store, then a load of the result register, and a batch walks its words
// one at a time. One item is in flight at a time; in_ready_o is high while idle.
// Reset clears pointers, close mark and sequencer and sets capacity_log2 to 4;
// the ring store needs no clearing pass. A stalled result holds the sequencer
// until out_ready_i; a capacity write empties the FIFO.
//
module closable_ring_fifo_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [crf_pkg::KIND_W-1:0]    kind_i,
  input  logic [crf_pkg::DATA_W-1:0]    data_i,
  input  logic [crf_pkg::MAXC_W-1:0]    max_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [crf_pkg::STATUS_W-1:0]  status_o,
  output logic [crf_pkg::DATA_W-1:0]    data_res_o,
  output logic                          has_data_o,
  output logic                          last_o,
  output logic [crf_pkg::CNT_W-1:0]     count_o,
  output logic                          closed_o,
  output logic                          drained_o,
  input  logic                          cfg_we_i,
  input  logic [crf_pkg::CAPL_W-1:0]    cfg_data_i
);
  import crf_pkg::*;

  crf_cmd_t  cmd;
  crf_stat_t stat;

  // Sequence items and batch runs.
  crf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .max_count_i (max_count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the ring, pointers and result register.
  crf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .data_i     (data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status_o),
    .data_res_o (data_res_o),
    .has_data_o (has_data_o),
    .last_o     (last_o),
    .count_o    (count_o),
    .closed_o   (closed_o),
    .drained_o  (drained_o)
  );

  // Never take an item while a result is pending.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result is pending");

  // Fill level never exceeds the built depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(DEPTH)))
    else $error("result count exceeds depth");

  // A word is only returned with status ok.
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_data_o) |-> (status_o == ST_OK))
    else $error("word returned with a failing status");

  // A result that is not the last one is followed by another word.
  a_batch_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> !in_ready_o)
    else $error("batch run ended without a last mark");

endmodule
